// File: hdl/awnn_pkg.sv
// ----------------------------------------------------------------------------
// awnn_pkg
// Shared types and constants for the affine warp nearest-neighbor core:
// item layouts, request codes, register indexes and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package awnn_pkg;

  // Parameter defaults
  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;
  localparam int PIXEL_BITS_DEF = 8;
  localparam int FRAC_BITS_DEF  = 16;

  // Fixed field widths
  localparam int COORD_W    = 9;
  localparam int PIX_FIELD_W = 8;
  localparam int COEF_W     = 24;
  localparam int OFFSET_W   = 28;
  localparam int DIM_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;

  // Request codes
  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_FETCH = 1'b1
  } req_type_t;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_XU      = 3'd0,
    REG_COEF_XV      = 3'd1,
    REG_OFFSET_X     = 3'd2,
    REG_COEF_YU      = 3'd3,
    REG_COEF_YV      = 3'd4,
    REG_OFFSET_Y     = 3'd5,
    REG_IMAGE_WIDTH  = 3'd6,
    REG_IMAGE_HEIGHT = 3'd7
  } cfg_reg_t;

  // Register reset values
  localparam logic [COEF_W-1:0]   COEF_ONE     = COEF_W'(65536);
  localparam logic [COEF_W-1:0]   COEF_ZERO    = '0;
  localparam logic [OFFSET_W-1:0] OFFSET_ZERO  = '0;
  localparam logic [DIM_W-1:0]    DIM_RESET    = DIM_W'(512);

  // Input item
  typedef struct packed {
    req_type_t                req_type;
    logic [COORD_W-1:0]       col;
    logic [COORD_W-1:0]       row;
    logic [PIX_FIELD_W-1:0]   pixel_in;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [PIX_FIELD_W-1:0]   pixel_out;
    logic                     outside;
  } out_item_t;

endpackage

`default_nettype wire

// File: hdl/affine_warp_nearest_neighbor_core.sv
// ----------------------------------------------------------------------------
// affine_warp_nearest_neighbor_core
// Inverse-mapped affine warp with nearest-neighbor sampling over an on-chip
// frame store. Load items write source pixels, fetch items return the pixel
// at the rounded source point of an output coordinate, or 0 when outside.
// ----------------------------------------------------------------------------
//
//  channel  | signals                           | direction | handshake
//  ---------+-----------------------------------+-----------+-------------------
//  item     | item_valid, item_stall, item      | in        | valid && !stall
//  result   | result_valid, result_stall, result| out       | valid && !stall
//  cfg      | cfg_valid, cfg_ready, cfg_index,  | in        | valid && ready
//           | cfg_data                          |           |
//
//  Items pass through latch, four multiplies, two sums, then the frame store
//  port, one item per cycle sustained while the result is not stalled. Loads
//  write the store from the sum stage and produce no result.
//  Reset clears the pipeline valids and restores the register defaults; the
//  frame store has no reset. A stalled result holds the whole pipeline.
//
`default_nettype none

module affine_warp_nearest_neighbor_core #(
  parameter int MAX_WIDTH  = awnn_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = awnn_pkg::MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = awnn_pkg::PIXEL_BITS_DEF,
  parameter int FRAC_BITS  = awnn_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire awnn_pkg::in_item_t            item,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output awnn_pkg::out_item_t                result,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [awnn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [awnn_pkg::CFG_DATA_W-1:0] cfg_data
);

  import awnn_pkg::*;

  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int YW      = $clog2(MAX_HEIGHT);
  localparam int PROD_W  = COEF_W + COORD_W + 1;
  localparam int SUM_W   = PROD_W + 2;
  localparam int INT_W   = SUM_W - FRAC_BITS;
  localparam int BW_X    = $clog2(MAX_WIDTH + 1);
  localparam int BW_Y    = $clog2(MAX_HEIGHT + 1);
  localparam int BW_XY   = (BW_X > BW_Y) ? BW_X : BW_Y;
  localparam int BND_W   = (BW_XY > DIM_W) ? BW_XY : DIM_W;
  localparam int CMP_W   = ((INT_W > BND_W) ? INT_W : BND_W) + 1;
  localparam int PIX_EXT = (PIXEL_BITS > PIX_FIELD_W) ? PIXEL_BITS : PIX_FIELD_W;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

  // Configuration registers
  logic [COEF_W-1:0]   coef_xu, coef_xv, coef_yu, coef_yv;
  logic [OFFSET_W-1:0] offset_x, offset_y;
  logic [DIM_W-1:0]    image_width, image_height;

  // Pipeline registers
  logic                       s1_valid, s2_valid, s3_valid, s4_valid;
  req_type_t                  s1_type, s2_type, s3_type, s4_type;
  logic [COORD_W-1:0]         s1_col, s1_row, s2_col, s2_row, s3_col, s3_row;
  logic [PIX_FIELD_W-1:0]     s1_pix, s2_pix, s3_pix;
  logic signed [PROD_W-1:0]   s2_xu, s2_xv, s2_yu, s2_yv;
  logic signed [SUM_W-1:0]    s3_sum_x, s3_sum_y;
  logic                       s4_outside;
  logic [PIXEL_BITS-1:0]      rd_data;

  // Frame store
  logic [PIXEL_BITS-1:0]      mem [DEPTH];

  // Stage 3 combinational values
  logic                       advance;
  logic signed [INT_W-1:0]    x_int, y_int;
  logic [CMP_W-1:0]           x_cmp, y_cmp, w_cmp, h_cmp;
  logic [BND_W-1:0]           w_sat, h_sat;
  logic                       in_bounds;
  logic [ADDR_W-1:0]          rd_addr, wr_addr;
  logic                       wr_en;
  logic [PIX_EXT-1:0]         wr_ext, rd_ext;

  assign cfg_ready  = 1'b1;
  assign advance    = !(result_valid && result_stall);
  assign item_stall = !advance;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_xu      <= COEF_ONE;
      coef_xv      <= COEF_ZERO;
      offset_x     <= OFFSET_ZERO;
      coef_yu      <= COEF_ZERO;
      coef_yv      <= COEF_ONE;
      offset_y     <= OFFSET_ZERO;
      image_width  <= DIM_RESET;
      image_height <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_COEF_XU:      coef_xu      <= cfg_data[COEF_W-1:0];
        REG_COEF_XV:      coef_xv      <= cfg_data[COEF_W-1:0];
        REG_OFFSET_X:     offset_x     <= cfg_data[OFFSET_W-1:0];
        REG_COEF_YU:      coef_yu      <= cfg_data[COEF_W-1:0];
        REG_COEF_YV:      coef_yv      <= cfg_data[COEF_W-1:0];
        REG_OFFSET_Y:     offset_y     <= cfg_data[OFFSET_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= item_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // Latch the item, multiply, sum with offset and rounding half, then register the bounds flag
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_type  <= item.req_type;
      s1_col   <= item.col;
      s1_row   <= item.row;
      s1_pix   <= item.pixel_in;

      s2_type  <= s1_type;
      s2_col   <= s1_col;
      s2_row   <= s1_row;
      s2_pix   <= s1_pix;
      s2_xu    <= PROD_W'($signed(coef_xu) * $signed({1'b0, s1_col}));
      s2_xv    <= PROD_W'($signed(coef_xv) * $signed({1'b0, s1_row}));
      s2_yu    <= PROD_W'($signed(coef_yu) * $signed({1'b0, s1_col}));
      s2_yv    <= PROD_W'($signed(coef_yv) * $signed({1'b0, s1_row}));

      s3_type  <= s2_type;
      s3_col   <= s2_col;
      s3_row   <= s2_row;
      s3_pix   <= s2_pix;
      s3_sum_x <= SUM_W'(s2_xu) + SUM_W'(s2_xv) + SUM_W'($signed(offset_x)) + HALF;
      s3_sum_y <= SUM_W'(s2_yu) + SUM_W'(s2_yv) + SUM_W'($signed(offset_y)) + HALF;

      s4_type    <= s3_type;
      s4_outside <= !in_bounds;
    end
  end

  // Floor, bounds check and store addressing
  always_comb begin
    x_int   = INT_W'(s3_sum_x >>> FRAC_BITS);
    y_int   = INT_W'(s3_sum_y >>> FRAC_BITS);
    x_cmp   = CMP_W'(x_int);
    y_cmp   = CMP_W'(y_int);
    w_sat   = (BND_W'(image_width) > BND_W'(MAX_WIDTH)) ? BND_W'(MAX_WIDTH)
                                                        : BND_W'(image_width);
    h_sat   = (BND_W'(image_height) > BND_W'(MAX_HEIGHT)) ? BND_W'(MAX_HEIGHT)
                                                          : BND_W'(image_height);
    w_cmp   = CMP_W'(w_sat);
    h_cmp   = CMP_W'(h_sat);
    in_bounds = !x_int[INT_W-1] && !y_int[INT_W-1] && (x_cmp < w_cmp) && (y_cmp < h_cmp);
    rd_addr = ADDR_W'(y_int[YW-1:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x_int[XW-1:0]);
    wr_addr = ADDR_W'(s3_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(s3_col);
    wr_en   = advance && s3_valid && (s3_type == REQ_LOAD)
              && (BND_W'(s3_col) < BND_W'(MAX_WIDTH))
              && (BND_W'(s3_row) < BND_W'(MAX_HEIGHT));
    wr_ext  = PIX_EXT'(s3_pix);
  end

  // Write the frame store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_ext[PIXEL_BITS-1:0];
    end
  end

  // Read the frame store, hold under stall
  always_ff @(posedge clk) begin
    if (advance) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Drive the result item
  always_comb begin
    rd_ext           = PIX_EXT'(rd_data);
    result_valid     = s4_valid && (s4_type == REQ_FETCH);
    result.outside   = s4_outside;
    result.pixel_out = s4_outside ? '0 : rd_ext[PIX_FIELD_W-1:0];
  end

endmodule

`default_nettype wire
